[src/fcct_pkg.sv]
// shared types and constants for the four-channel counter/timer
`default_nettype none

package fcct_pkg;

   localparam int CYCLE_W = 12;

   localparam logic [2:0] OP_WRITE   = 3'd0;
   localparam logic [2:0] OP_READ    = 3'd1;
   localparam logic [2:0] OP_ADVANCE = 3'd2;
   localparam logic [2:0] OP_TRIGGER = 3'd3;
   localparam logic [2:0] OP_ACK     = 3'd4;

   localparam int CW_CONTROL    = 0;
   localparam int CW_RESET      = 1;
   localparam int CW_TC_FOLLOWS = 2;
   localparam int CW_TRIG_WAIT  = 3;
   localparam int CW_PRE256     = 5;
   localparam int CW_COUNTER    = 6;
   localparam int CW_IRQ_EN     = 7;

   localparam logic [7:0] VECTOR_MASK = 8'hf8;
   localparam logic [8:0] PRE_LONG    = 9'd256;
   localparam logic [8:0] PRE_SHORT   = 9'd16;

   typedef struct packed {
      logic [2:0]         op;
      logic [1:0]         channel;
      logic [7:0]         wdata;
      logic [CYCLE_W-1:0] cycles;
   } fcct_req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       irq_taken;
      logic [7:0] irq_vector;
      logic       irq_request;
   } fcct_rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic add;
      logic step;
      logic load_out;
   } fcct_cmd_type;

   typedef struct packed {
      logic is_adv;
      logic step_ready;
   } fcct_stat_type;

endpackage

`default_nettype wire

[src/fcct_ctrl.sv]
// controller state machine: sequences operations and prescaler periods
`default_nettype none

module fcct_ctrl import fcct_pkg::*; #(
   parameter int CHANNELS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire fcct_stat_type               stat,
   output fcct_cmd_type                     cmd,
   output logic [$clog2(CHANNELS)-1:0]      adv_ch
);

   localparam int CH_W = $clog2(CHANNELS);
   localparam logic [CH_W-1:0] LAST = CH_W'(CHANNELS - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_ADD  = 5'b00100,
      S_STEP = 5'b01000,
      S_DONE = 5'b10000
   } fcct_state_type;

   fcct_state_type  state_ff, state_in;
   logic [CH_W-1:0] chan_ff, chan_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_adv) begin
               chan_in  = '0;
               state_in = S_ADD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (stat.step_ready) begin
               cmd.step = 1'b1;
            end else if (chan_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = S_ADD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign adv_ch       = chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !req_stall) |=> (state_ff == S_EXEC))
      else $error("transfer not followed by execute");

   a_step_only_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (state_ff == S_STEP && stat.step_ready))
      else $error("prescaler step without a full period");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid_ff) && $past(!reset)) |-> $past(!rsp_stall))
      else $error("result dropped while stalled");

endmodule

`default_nettype wire

[src/fcct_dp.sv]
// datapath: channel registers, count logic, interrupt priority and result register
`default_nettype none

module fcct_dp import fcct_pkg::*; #(
   parameter int CHANNELS   = 4,
   parameter int CYCLE_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fcct_req_type                req_data,
   output fcct_rsp_type                     rsp_data,
   input  wire fcct_cmd_type                cmd,
   input  wire logic [$clog2(CHANNELS)-1:0] adv_ch,
   output fcct_stat_type                    stat
);

   localparam int CH_W   = $clog2(CHANNELS);
   localparam int CB_USE = (CYCLE_BITS < CYCLE_W) ? CYCLE_BITS : CYCLE_W;
   localparam int ACC_W  = ((CB_USE > 8) ? CB_USE : 8) + 1;

   logic [7:0]       cw_ff    [CHANNELS];
   logic [7:0]       cw_in    [CHANNELS];
   logic [7:0]       tc_ff    [CHANNELS];
   logic [7:0]       tc_in    [CHANNELS];
   logic [7:0]       dc_ff    [CHANNELS];
   logic [7:0]       dc_in    [CHANNELS];
   logic [ACC_W-1:0] acc_ff   [CHANNELS];
   logic [ACC_W-1:0] acc_in   [CHANNELS];
   logic [ACC_W-1:0] pre_v    [CHANNELS];
   logic [CHANNELS-1:0] await_ff, await_in;
   logic [CHANNELS-1:0] run_ff, run_in;
   logic [CHANNELS-1:0] pend_ff, pend_in;
   logic [CHANNELS-1:0] rdy_v, wr_v, trig_v, cd_v, start_v, stp_v, add_v, clr_v;
   logic [7:0]       vbase_ff, vbase_in;

   fcct_req_type     item_ff;
   fcct_rsp_type     res_ff, res_in;
   fcct_rsp_type     out_ff, out_in;

   logic             ch_ok;
   logic [CH_W-1:0]  sel_ch;
   logic             ack_hit;
   logic [CH_W-1:0]  ack_idx;
   logic             zero0;
   logic [ACC_W-1:0] cyc_ext;
   logic [7:0]       d;

   assign ch_ok   = (32'(item_ff.channel) < CHANNELS);
   assign sel_ch  = CH_W'(item_ff.channel);
   assign cyc_ext = ACC_W'(item_ff.cycles[CB_USE-1:0]);
   assign d       = item_ff.wdata;

   always_comb begin
      ack_hit = 1'b0;
      ack_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            ack_hit = 1'b1;
            ack_idx = CH_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         pre_v[i] = cw_ff[i][CW_PRE256] ? ACC_W'(PRE_LONG) : ACC_W'(PRE_SHORT);
         rdy_v[i] = run_ff[i] && !cw_ff[i][CW_COUNTER] && (acc_ff[i] >= pre_v[i]);
      end
   end

   assign stat.step_ready = rdy_v[adv_ch];
   assign stat.is_adv     = (item_ff.op == OP_ADVANCE);

   // channel 0 reaching zero, which cascades a trigger into channel 1
   assign zero0 = (dc_ff[0] == 8'd1) &&
                  ((cmd.exec && item_ff.op == OP_TRIGGER && ch_ok && sel_ch == '0 &&
                    cw_ff[0][CW_COUNTER] && run_ff[0]) ||
                   (cmd.step && adv_ch == '0));

   always_comb begin
      cw_in    = cw_ff;
      tc_in    = tc_ff;
      dc_in    = dc_ff;
      acc_in   = acc_ff;
      await_in = await_ff;
      run_in   = run_ff;
      pend_in  = pend_ff;
      vbase_in = vbase_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         wr_v[i]    = cmd.exec && item_ff.op == OP_WRITE && ch_ok && sel_ch == CH_W'(i);
         trig_v[i]  = (cmd.exec && item_ff.op == OP_TRIGGER && ch_ok &&
                       sel_ch == CH_W'(i)) || (i == 1 && zero0);
         stp_v[i]   = cmd.step && adv_ch == CH_W'(i);
         add_v[i]   = cmd.add && adv_ch == CH_W'(i) && run_ff[i] && !cw_ff[i][CW_COUNTER];
         clr_v[i]   = cmd.exec && item_ff.op == OP_ACK && ack_hit && ack_idx == CH_W'(i);
         cd_v[i]    = (trig_v[i] && cw_ff[i][CW_COUNTER] && run_ff[i]) || stp_v[i];
         start_v[i] = trig_v[i] && !cw_ff[i][CW_COUNTER] && !run_ff[i] &&
                      cw_ff[i][CW_TRIG_WAIT];

         if (wr_v[i]) begin
            if (await_ff[i]) begin
               tc_in[i]    = d;
               dc_in[i]    = d;
               await_in[i] = 1'b0;
               acc_in[i]   = '0;
               run_in[i]   = cw_ff[i][CW_COUNTER] || !cw_ff[i][CW_TRIG_WAIT];
            end else if (d[CW_CONTROL]) begin
               cw_in[i] = d;
               if (d[CW_RESET]) begin
                  run_in[i]  = 1'b0;
                  pend_in[i] = 1'b0;
               end
               if (d[CW_TC_FOLLOWS]) begin
                  await_in[i] = 1'b1;
               end else if (!(d[CW_RESET] || d[CW_COUNTER] || d[CW_TRIG_WAIT])) begin
                  run_in[i] = 1'b1;
               end
            end else if (i == 0) begin
               vbase_in = d & VECTOR_MASK;
            end
         end
         if (cd_v[i]) begin
            if (dc_ff[i] == 8'd1) begin
               dc_in[i] = tc_ff[i];
               if (cw_ff[i][CW_IRQ_EN]) begin
                  pend_in[i] = 1'b1;
               end
            end else begin
               dc_in[i] = dc_ff[i] - 8'd1;
            end
         end
         if (start_v[i]) begin
            run_in[i] = 1'b1;
            dc_in[i]  = tc_ff[i];
            acc_in[i] = '0;
         end
         if (stp_v[i]) begin
            acc_in[i] = acc_ff[i] - pre_v[i];
         end
         if (add_v[i]) begin
            acc_in[i] = acc_ff[i] + cyc_ext;
         end
         if (clr_v[i]) begin
            pend_in[i] = 1'b0;
         end
      end
   end

   always_comb begin
      res_in             = '0;
      res_in.rdata       = (item_ff.op == OP_READ && ch_ok) ? dc_ff[sel_ch] : 8'd0;
      res_in.irq_taken   = (item_ff.op == OP_ACK) && ack_hit;
      res_in.irq_vector  = res_in.irq_taken ? (vbase_ff | (8'(ack_idx) << 1)) : 8'd0;
      out_in             = res_ff;
      out_in.irq_request = |pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            cw_ff[i]  <= '0;
            tc_ff[i]  <= '0;
            dc_ff[i]  <= '0;
            acc_ff[i] <= '0;
         end
         await_ff <= '0;
         run_ff   <= '0;
         pend_ff  <= '0;
         vbase_ff <= '0;
      end else begin
         cw_ff    <= cw_in;
         tc_ff    <= tc_in;
         dc_ff    <= dc_in;
         acc_ff   <= acc_in;
         await_ff <= await_in;
         run_ff   <= run_in;
         pend_ff  <= pend_in;
         vbase_ff <= vbase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.exec) begin
         res_ff <= res_in;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && item_ff.op == OP_ACK && ack_hit) |=> !pend_ff[$past(ack_idx)])
      else $error("acknowledged interrupt still pending");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (acc_ff[adv_ch] >= pre_v[adv_ch]))
      else $error("prescaler accumulator underflow");

   a_cascade_ch0: assert property (@(posedge clock) disable iff (reset)
      zero0 |-> (cd_v[0] && dc_ff[0] == 8'd1))
      else $error("cascade without channel 0 reaching zero");

endmodule

`default_nettype wire

[src/four_channel_counter_timer.sv]
// four-channel counter/timer with vectored interrupt acknowledge
// write, read, trigger and acknowledge go through the execute and done states; the result is registered on leaving done
// advance goes through execute, then an add and a step state for each channel, then done
// a new request is taken only in idle, once the last item has left its execute and done states
// an advance walks the channels in order, one prescaler period per cycle through a shared step
// reset is synchronous and active high, clears all channel state, nothing else to sweep
`default_nettype none

module four_channel_counter_timer import fcct_pkg::*; #(
   parameter int CHANNELS   = 4,
   parameter int CYCLE_BITS = 12
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire fcct_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output fcct_rsp_type      rsp_data
);

   fcct_cmd_type                cmd;
   fcct_stat_type               stat;
   logic [$clog2(CHANNELS)-1:0] adv_ch;

   fcct_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .adv_ch    (adv_ch)
   );

   fcct_dp #(
      .CHANNELS   (CHANNELS),
      .CYCLE_BITS (CYCLE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .adv_ch   (adv_ch),
      .stat     (stat)
   );

endmodule

`default_nettype wire
